### rtl/first_word_substring_replace_assert.svh
// Assertion macros used by the top level of the streaming find-and-replace block.
`ifndef FIRST_WORD_SUBSTRING_REPLACE_ASSERT_SVH
`define FIRST_WORD_SUBSTRING_REPLACE_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define FWSR_ASSERT_ALWAYS(label, ck, rn, cond, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define FWSR_ASSERT_IMPLY(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FWSR_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/fwsr_pkg.sv
// Types and constants shared by the find-and-replace block.
package fwsr_pkg;

  localparam int REG_CHARS = 8;
  localparam int CHAR_IDX_W = 3;
  localparam logic [3:0] REG_CHARS4 = 4'd8;
  localparam logic [7:0] SPACE_CHAR = 8'h20;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QLVL_W = 3;

  typedef enum logic [1:0] {
    REG_PAT_LEN   = 2'd0,
    REG_PAT_CHARS = 2'd1,
    REG_REP_LEN   = 2'd2,
    REG_REP_CHARS = 2'd3
  } fwsr_reg_t;

  typedef struct packed {
    logic [3:0]  pat_len;
    logic [63:0] pat_chars;
    logic [3:0]  rep_len;
    logic [63:0] rep_chars;
  } fwsr_cfg_t;

  // One queued work unit: emit chars[0..count-1], then mark the name end if last.
  typedef struct packed {
    logic [REG_CHARS-1:0][7:0] chars;
    logic [3:0]                count;
    logic                      last;
  } fwsr_cmd_t;

  typedef struct packed {
    logic [3:0] fill;
    logic       seen;
  } fwsr_front_stat_t;

  typedef struct packed {
    logic [QLVL_W-1:0] level;
    logic              full;
    logic              empty;
  } fwsr_q_stat_t;

endpackage

### rtl/fwsr_channels.sv
// Handshake interfaces for the character input and result channels.
interface fwsr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       name_end;

  modport source (output valid, output in_char, output name_end, input ready);
  modport sink (input valid, input in_char, input name_end, output ready);
endinterface

interface fwsr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       last_of_name;

  modport source (output valid, output out_char, output char_valid,
                  output last_of_name, input ready);
  modport sink (input valid, input out_char, input char_valid,
                input last_of_name, output ready);
endinterface

### rtl/fwsr_cfg.sv
// APB-style register file holding the pattern and replacement settings.
module fwsr_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready,
  output fwsr_pkg::fwsr_cfg_t cfg
);
  import fwsr_pkg::*;

  logic [3:0]  pat_len_r;
  logic [63:0] pat_chars_r;
  logic [3:0]  rep_len_r;
  logic [63:0] rep_chars_r;
  logic        wr_en;
  fwsr_reg_t   reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = fwsr_reg_t'(paddr[4:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r   <= 4'd1;
      pat_chars_r <= '0;
      rep_len_r   <= '0;
      rep_chars_r <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_PAT_LEN:   pat_len_r   <= pwdata[3:0];
        REG_PAT_CHARS: pat_chars_r <= pwdata;
        REG_REP_LEN:   rep_len_r   <= pwdata[3:0];
        REG_REP_CHARS: rep_chars_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_PAT_LEN:   prdata = {60'd0, pat_len_r};
      REG_PAT_CHARS: prdata = pat_chars_r;
      REG_REP_LEN:   prdata = {60'd0, rep_len_r};
      REG_REP_CHARS: prdata = rep_chars_r;
      default:       prdata = '0;
    endcase
  end

  assign cfg.pat_len   = pat_len_r;
  assign cfg.pat_chars = pat_chars_r;
  assign cfg.rep_len   = rep_len_r;
  assign cfg.rep_chars = rep_chars_r;

endmodule

### rtl/fwsr_front.sv
// Front end: matches each character against the pattern and queues the output it causes.
module fwsr_front #(
  parameter int PAT_CAP = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic [7:0]                 in_char,
  input  logic                       name_end,
  input  fwsr_pkg::fwsr_cfg_t        cfg,
  output fwsr_pkg::fwsr_cmd_t        cmd,
  output logic                       cmd_push,
  output fwsr_pkg::fwsr_front_stat_t stat
);
  import fwsr_pkg::*;

  localparam int FILL_W = $clog2(PAT_CAP + 1);
  localparam int IDX_W  = (PAT_CAP > 1) ? $clog2(PAT_CAP) : 1;
  localparam logic [3:0] CAP4 = 4'(PAT_CAP);

  logic [7:0]        win_r [PAT_CAP];
  logic [7:0]        win_nxt [PAT_CAP];
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              seen_r, seen_nxt;
  logic              done_r, done_nxt;

  logic [3:0]        plen, rlen;
  logic [FILL_W-1:0] plen_f, f;
  logic [7:0]        w [PAT_CAP];
  logic [FILL_W-1:0] lens [PAT_CAP];
  logic [PAT_CAP-1:0] stop, is_sp, is_rep;
  logic              all_ok, pre;
  logic [IDX_W-1:0]  sel;
  logic              found, take_rep, hold;

  always_comb begin
    plen = cfg.pat_len;
    if (plen == 4'd0) begin
      plen = 4'd1;
    end else if (plen > CAP4) begin
      plen = CAP4;
    end
    rlen   = (cfg.rep_len > REG_CHARS4) ? REG_CHARS4 : cfg.rep_len;
    plen_f = FILL_W'(plen);
    f      = fill_r + FILL_W'(1);

    // Held characters followed by the new one.
    for (int j = 0; j < PAT_CAP; j++) begin
      w[j] = (FILL_W'(j) < fill_r) ? win_r[j] : in_char;
    end

    // For every start offset: does a space or a (possibly complete) match begin there?
    for (int d = 0; d < PAT_CAP; d++) begin
      lens[d] = f - FILL_W'(d);
      all_ok  = 1'b1;
      for (int k = 0; k < PAT_CAP; k++) begin
        if (d + k < PAT_CAP) begin
          if (FILL_W'(d + k) < f && w[d + k] != cfg.pat_chars[8*k +: 8]) begin
            all_ok = 1'b0;
          end
        end
      end
      is_sp[d]  = (FILL_W'(d) < f) && (w[d] == SPACE_CHAR);
      pre       = (FILL_W'(d) < f) && (lens[d] <= plen_f) && all_ok;
      is_rep[d] = pre && (d == 0) && (lens[d] == plen_f);
      stop[d]   = is_sp[d] || (pre && (lens[d] < plen_f)) || is_rep[d];
    end

    found = 1'b0;
    sel   = '0;
    for (int d = PAT_CAP - 1; d >= 0; d--) begin
      if (stop[d]) begin
        found = 1'b1;
        sel   = IDX_W'(d);
      end
    end
    take_rep = found && !is_sp[sel] && is_rep[sel];
    hold     = found && !is_sp[sel] && !is_rep[sel];

    for (int j = 0; j < REG_CHARS; j++) begin
      cmd.chars[j] = (j < PAT_CAP) ? w[j] : 8'd0;
    end
    cmd.count = 4'd1;
    cmd.last  = name_end;
    win_nxt   = win_r;
    fill_nxt  = fill_r;
    seen_nxt  = seen_r;
    done_nxt  = done_r;

    if (!seen_r || done_r) begin
      // First character of a name, or scanning already over: pass through.
      seen_nxt = 1'b1;
    end else if (take_rep) begin
      for (int j = 0; j < REG_CHARS; j++) begin
        cmd.chars[j] = cfg.rep_chars[8*j +: 8];
      end
      cmd.count = rlen;
      fill_nxt  = '0;
    end else if (hold && !name_end) begin
      // Characters ahead of a partial match leave; the partial match stays held.
      cmd.count = 4'(sel);
      fill_nxt  = f - FILL_W'(sel);
      for (int j = 0; j < PAT_CAP; j++) begin
        for (int d = 0; d < PAT_CAP; d++) begin
          if (d + j < PAT_CAP && IDX_W'(d) == sel) begin
            win_nxt[j] = w[d + j];
          end
        end
      end
    end else begin
      cmd.count = 4'(f);
      fill_nxt  = '0;
      if (found && is_sp[sel]) begin
        done_nxt = 1'b1;
      end
    end

    if (name_end) begin
      fill_nxt = '0;
      seen_nxt = 1'b0;
      done_nxt = 1'b0;
    end
  end

  assign cmd_push = accept && ((cmd.count != 4'd0) || name_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      seen_r <= 1'b0;
      done_r <= 1'b0;
    end else if (accept) begin
      fill_r <= fill_nxt;
      seen_r <= seen_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

  assign stat.fill = 4'(fill_r);
  assign stat.seen = seen_r;

endmodule

### rtl/fwsr_queue.sv
// Short command queue between the matching front end and the output sequencer.
module fwsr_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  fwsr_pkg::fwsr_cmd_t    wdata,
  input  logic                   pop,
  output fwsr_pkg::fwsr_cmd_t    rdata,
  output fwsr_pkg::fwsr_q_stat_t stat
);
  import fwsr_pkg::*;

  fwsr_cmd_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QLVL_W-1:0] level_r, level_nxt;

  always_comb begin
    level_nxt = level_r;
    if (push && !pop) begin
      level_nxt = level_r + QLVL_W'(1);
    end else if (pop && !push) begin
      level_nxt = level_r - QLVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata      = mem_r[rd_ptr_r];
  assign stat.level = level_r;
  assign stat.full  = (level_r == QLVL_W'(QDEPTH));
  assign stat.empty = (level_r == '0);

endmodule

### rtl/fwsr_back.sv
// Back end: plays out each queued command one character per transaction.
module fwsr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  fwsr_pkg::fwsr_cmd_t head,
  input  logic                head_valid,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_char,
  output logic                char_valid,
  output logic                last_of_name
);
  import fwsr_pkg::*;

  logic [CHAR_IDX_W-1:0] idx_r, idx_nxt;
  logic                  bare, is_final, fire;

  // A command with no characters is a bare end-of-name mark.
  assign bare     = (head.count == 4'd0);
  assign is_final = bare || ({1'b0, idx_r} == head.count - 4'd1);
  assign fire     = head_valid && out_ready;

  assign out_valid    = head_valid;
  assign out_char     = bare ? 8'd0 : head.chars[idx_r];
  assign char_valid   = !bare;
  assign last_of_name = head.last && is_final;
  assign pop          = fire && is_final;

  always_comb begin
    idx_nxt = idx_r;
    if (fire) begin
      idx_nxt = is_final ? '0 : idx_r + CHAR_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

### rtl/first_word_substring_replace.sv
// Top level of the streaming find-and-replace block for the first word of a name.
// Characters of a name enter on in_ch, one per transaction, with name_end on the
// final one. Character 0 and everything from the first space that could start a
// match pass through; in between, each occurrence of the pattern is replaced.
// Results leave on out_ch, one character per transaction; last_of_name marks the
// final result of a name, and a bare end mark (char_valid low) is sent when the
// name's final character produces nothing. Pattern and replacement are set over
// the APB port; the user must write them only while the block is idle (not enforced).
// The first result of a character is registered in the command queue before it is offered.
// Throughput: one character per cycle while each yields at most one result and
// out_ch does not stall; a character that releases k results holds the output
// sequencer for k transactions, and a 4-entry command queue lets input continue
// meanwhile. When out_ch stalls, the queue fills; in_ch.ready drops once it is full.
// Reset clears the queue, the held match window and the per-name state, and
// restores the registers to a one-character zero pattern and empty replacement.
module first_word_substring_replace #(
  parameter int MAX_PATTERN = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  fwsr_in_if.sink      in_ch,
  fwsr_out_if.source   out_ch,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);
  import fwsr_pkg::*;

  `include "first_word_substring_replace_assert.svh"

  localparam int PAT_CAP = (MAX_PATTERN < REG_CHARS) ? MAX_PATTERN : REG_CHARS;

  fwsr_cfg_t        cfg;
  fwsr_cmd_t        cmd, head;
  fwsr_front_stat_t front_stat;
  fwsr_q_stat_t     q_stat;
  logic             in_accept, q_push, q_pop;

  assign in_ch.ready = !q_stat.full;
  assign in_accept   = in_ch.valid && in_ch.ready;

  fwsr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fwsr_front #(
    .PAT_CAP (PAT_CAP)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .in_char  (in_ch.in_char),
    .name_end (in_ch.name_end),
    .cfg      (cfg),
    .cmd      (cmd),
    .cmd_push (q_push),
    .stat     (front_stat)
  );

  fwsr_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (cmd),
    .pop   (q_pop),
    .rdata (head),
    .stat  (q_stat)
  );

  fwsr_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .head_valid   (!q_stat.empty),
    .pop          (q_pop),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_char     (out_ch.out_char),
    .char_valid   (out_ch.char_valid),
    .last_of_name (out_ch.last_of_name)
  );

  // The held partial match is always shorter than the longest pattern.
  `FWSR_ASSERT_ALWAYS(a_fill_below_cap, clk, rst_n, front_stat.fill < 4'(PAT_CAP), "window overfull")
  // The end of a name leaves no held characters and restarts at character 0.
  `FWSR_ASSERT_NEXT(a_end_clears, clk, rst_n, in_accept && in_ch.name_end, front_stat.fill == 4'd0 && !front_stat.seen, "name state not cleared")
  // A command is never pushed into a full queue.
  `FWSR_ASSERT_IMPLY(a_no_overflow, clk, rst_n, q_push, !q_stat.full, "queue overflow")
  // A bare mark only closes a name and carries a zero character.
  `FWSR_ASSERT_IMPLY(a_bare_is_last, clk, rst_n, out_ch.valid && !out_ch.char_valid, out_ch.last_of_name && out_ch.out_char == 8'd0, "bare mark not at name end")

endmodule
